### hw/rtl/mwpt_pkg.sv
//------------------------------------------------------------------------------
// mwpt_pkg
// shared types and constants for the polygon triangulation block
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package mwpt_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int WEIGHT_W         = 16;
    localparam int TOTAL_W          = 24;
    localparam int COUNT_W          = 5;
    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 5'd6;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIAG,
        ST_CHAIN,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_RD_D,
        ST_SUM,
        ST_WRITE,
        ST_FINAL,
        ST_DONE
    } seq_state_t;

endpackage

### hw/rtl/mwpt_wmem.sv
//------------------------------------------------------------------------------
// mwpt_wmem
// weight matrix memory, one write port, one registered read port
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwpt_wmem
    import mwpt_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    localparam int IDX_W = $clog2(MAX_VERTICES)
)
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic [2*IDX_W-1:0]  wr_addr,
    input  logic [WEIGHT_W-1:0] wr_data,
    input  logic [2*IDX_W-1:0]  rd_addr,
    output logic [WEIGHT_W-1:0] rd_data
);

    // row and column fields each take IDX_W address bits
    logic [WEIGHT_W-1:0] mem [2**(2*IDX_W)];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### hw/rtl/mwpt_cmem.sv
//------------------------------------------------------------------------------
// mwpt_cmem
// sub-chain cost memory, one write port, one registered read port
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwpt_cmem
    import mwpt_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    localparam int IDX_W = $clog2(MAX_VERTICES)
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [2*IDX_W-1:0] wr_addr,
    input  logic [TOTAL_W-1:0] wr_data,
    input  logic [2*IDX_W-1:0] rd_addr,
    output logic [TOTAL_W-1:0] rd_data
);

    // row and column fields each take IDX_W address bits
    logic [TOTAL_W-1:0] mem [2**(2*IDX_W)];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### hw/rtl/min_weight_polygon_triangulation.sv
//------------------------------------------------------------------------------
// min_weight_polygon_triangulation
// interval dynamic program for the minimum weight triangulation of a polygon
//------------------------------------------------------------------------------
// a load word does not raise busy; the next word is taken at once
// a compute word holds busy while it clears n-1 diagonal entries, then for each sub-chain
//   walks every split point with 2 cost reads and 3 weight reads
// the result strobe comes in the cycle after the done state, with busy already low; under 3
//   vertices the result is 0 and no table is filled; results cannot be stalled
// reset sets vertex_count to 6; memories are not cleared
`timescale 1ns / 1ps

module min_weight_polygon_triangulation
    import mwpt_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    localparam int IDX_W = $clog2(MAX_VERTICES),
    localparam int AW    = 2*IDX_W
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                command,
    input  logic [3:0]          row,
    input  logic [3:0]          col,
    input  logic [WEIGHT_W-1:0] weight_value,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [COUNT_W-1:0]  cfg_data,
    output logic                result_valid,
    output logic [TOTAL_W-1:0]  total_weight
);

    localparam int CNT_W = IDX_W + 1;

    seq_state_t         state_reg, state_next;
    logic [COUNT_W-1:0] vertex_count_reg;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [TOTAL_W-1:0] best_reg, best_next;
    logic [TOTAL_W+1:0] acc_reg, acc_next;
    logic [2:0]         ph_reg, ph_next;
    logic               first_reg, first_next;
    logic [TOTAL_W-1:0] res_reg, res_next;
    logic               rv_reg, rv_next;

    logic               w_we, c_we;
    logic [AW-1:0]      w_waddr, w_raddr, c_waddr, c_raddr;
    logic [WEIGHT_W-1:0] w_rdata;
    logic [TOTAL_W-1:0] c_wdata, c_rdata;
    logic [CNT_W-1:0]   j_val, a_val, n_sat;
    logic               accept;

    // memories
    mwpt_wmem #(.MAX_VERTICES(MAX_VERTICES)) u_wmem
    (
        .clk     (clk),
        .wr_en   (w_we),
        .wr_addr (w_waddr),
        .wr_data (weight_value),
        .rd_addr (w_raddr),
        .rd_data (w_rdata)
    );

    mwpt_cmem #(.MAX_VERTICES(MAX_VERTICES)) u_cmem
    (
        .clk     (clk),
        .wr_en   (c_we),
        .wr_addr (c_waddr),
        .wr_data (c_wdata),
        .rd_addr (c_raddr),
        .rd_data (c_rdata)
    );

    function automatic logic [AW-1:0] addr(input logic [CNT_W-1:0] r,
                                           input logic [CNT_W-1:0] c);
        return {r[IDX_W-1:0], c[IDX_W-1:0]};
    endfunction

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign accept    = start && !busy;
    assign result_valid = rv_reg;
    assign total_weight = res_reg;

    // weight write, only in range
    assign w_we    = accept && (command == CMD_LOAD) &&
                     ({4'd0, row} < 8'(MAX_VERTICES)) && ({4'd0, col} < 8'(MAX_VERTICES));
    assign w_waddr = addr(CNT_W'(row), CNT_W'(col));

    // saturated vertex count
    always_comb
    begin
        if (32'(vertex_count_reg) > MAX_VERTICES)
        begin
            n_sat = CNT_W'(MAX_VERTICES);
        end
        else
        begin
            n_sat = CNT_W'(vertex_count_reg);
        end
    end

    assign j_val = i_reg + len_reg - CNT_W'(1);
    assign a_val = i_reg - CNT_W'(1);

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VERTEX_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            vertex_count_reg <= cfg_data;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        len_reg   <= len_next;
        i_reg     <= i_next;
        k_reg     <= k_next;
        best_reg  <= best_next;
        acc_reg   <= acc_next;
        ph_reg    <= ph_next;
        first_reg <= first_next;
        res_reg   <= res_next;
    end

    // sequencer: per split point read cost(i,k), cost(k+1,j), then three weights
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        len_next   = len_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        best_next  = best_reg;
        acc_next   = acc_reg;
        ph_next    = ph_reg;
        first_next = first_reg;
        res_next   = res_reg;
        rv_next    = 1'b0;
        c_we       = 1'b0;
        c_waddr    = addr(i_reg, i_reg);
        c_wdata    = '0;
        c_raddr    = addr(i_reg, k_reg);
        w_raddr    = addr(a_val, k_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (command == CMD_COMPUTE))
                begin
                    n_next = n_sat;
                    i_next = CNT_W'(1);
                    if (n_sat < CNT_W'(3))
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_DIAG;
                    end
                end
            end
            ST_DIAG:
            begin
                c_we    = 1'b1;
                c_waddr = addr(i_reg, i_reg);
                if (i_reg == n_reg - CNT_W'(1))
                begin
                    len_next   = CNT_W'(2);
                    i_next     = CNT_W'(1);
                    state_next = ST_CHAIN;
                end
                else
                begin
                    i_next = i_reg + CNT_W'(1);
                end
            end
            ST_CHAIN:
            begin
                k_next     = i_reg;
                first_next = 1'b1;
                ph_next    = '0;
                state_next = ST_RD_A;
            end
            ST_RD_A:
            begin
                // issue cost(i,k)
                c_raddr    = addr(i_reg, k_reg);
                state_next = ST_RD_B;
            end
            ST_RD_B:
            begin
                // capture cost(i,k), issue cost(k+1,j)
                acc_next   = {2'b00, c_rdata};
                c_raddr    = addr(k_reg + CNT_W'(1), j_val);
                state_next = ST_RD_C;
            end
            ST_RD_C:
            begin
                // capture cost(k+1,j), issue w(a,k)
                acc_next   = acc_reg + {2'b00, c_rdata};
                w_raddr    = addr(a_val, k_reg);
                ph_next    = '0;
                state_next = ST_RD_D;
            end
            ST_RD_D:
            begin
                // walk through w(a,k), w(k,j), w(a,j)
                if (ph_reg == 3'd0)
                begin
                    w_raddr = addr(k_reg, j_val);
                    ph_next = 3'd1;
                end
                else if (ph_reg == 3'd1)
                begin
                    acc_next = acc_reg + (TOTAL_W+2)'(w_rdata);
                    w_raddr  = addr(a_val, j_val);
                    ph_next  = 3'd2;
                end
                else
                begin
                    acc_next   = acc_reg + (TOTAL_W+2)'(w_rdata);
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (first_reg || (acc_reg + (TOTAL_W+2)'(w_rdata) < {2'b00, best_reg}))
                begin
                    best_next = TOTAL_W'(acc_reg + (TOTAL_W+2)'(w_rdata));
                end
                first_next = 1'b0;
                if (k_reg + CNT_W'(1) == j_val)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    k_next     = k_reg + CNT_W'(1);
                    state_next = ST_RD_A;
                end
            end
            ST_WRITE:
            begin
                c_we    = 1'b1;
                c_waddr = addr(i_reg, j_val);
                c_wdata = best_reg;
                if (j_val == n_reg - CNT_W'(1))
                begin
                    if (len_reg == n_reg - CNT_W'(1))
                    begin
                        res_next   = best_reg;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        len_next   = len_reg + CNT_W'(1);
                        i_next     = CNT_W'(1);
                        state_next = ST_CHAIN;
                    end
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = ST_CHAIN;
                end
            end
            ST_FINAL:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                rv_next    = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // checks
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_DONE))
        else $error("result strobe without finished computation");

    a_no_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cfg_ready)
        else $error("config ready while busy");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_no_wmem_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        w_we |-> (state_reg == ST_IDLE))
        else $error("weight write during computation");

endmodule
